// ----- rtl/checksum_packet_deframer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the checksum packet deframer
// Clocked on clk and disabled while rst is high in the including module.
// ----------------------------------------------------------------------------
`ifndef CHECKSUM_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define CHECKSUM_PACKET_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define CPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpd assertion failed");

// Next-cycle implication
`define CPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpd assertion failed");

`else

`define CPD_ASSERT_NOW(lbl, ante, cons)
`define CPD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/cpd_pkg.sv -----
// ----------------------------------------------------------------------------
// cpd_pkg
// Types and codes shared by the checksum packet deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpd_pkg;

  // Result kind codes
  localparam logic [1:0] KIND_TYPE = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_HEADER  = 1'b0;
  localparam logic CFG_ADDRESS = 1'b1;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    ST_HUNT = 5'b00001,
    ST_LEN  = 5'b00010,
    ST_ADDR = 5'b00100,
    ST_TYPE = 5'b01000,
    ST_BODY = 5'b10000
  } phase_t;

  // One result from the parser to the output register
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic       good;
    logic       last;
  } result_t;

endpackage

// ----- rtl/cpd_parser.sv -----
// ----------------------------------------------------------------------------
// cpd_parser
// Framing state machine: header hunt, length, address, type, body, checksum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "checksum_packet_deframer_top_assert.svh"

module cpd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_in,
  input  logic [7:0]       header_byte,
  input  logic [7:0]       own_address,
  output cpd_pkg::result_t res
);
  import cpd_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] declared_length, declared_length_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] count_inc;
  logic [7:0] sum_inc;

  assign count_inc = byte_count + 8'd1;
  assign sum_inc   = running_sum + byte_in;

  // Next state and result for the byte in the input register
  always_comb begin
    phase_next           = phase;
    running_sum_next     = running_sum;
    declared_length_next = declared_length;
    byte_count_next      = byte_count;
    res                  = '0;
    case (phase)
      ST_HUNT: begin
        running_sum_next = byte_in;
        phase_next       = (byte_in == header_byte) ? ST_LEN : ST_HUNT;
      end
      ST_LEN: begin
        running_sum_next     = sum_inc;
        declared_length_next = byte_in;
        byte_count_next      = 8'd0;
        phase_next           = ST_ADDR;
      end
      ST_ADDR: begin
        running_sum_next = sum_inc;
        byte_count_next  = count_inc;
        phase_next       = (byte_in == own_address) ? ST_TYPE : ST_HUNT;
      end
      ST_TYPE: begin
        running_sum_next = sum_inc;
        byte_count_next  = count_inc;
        phase_next       = ST_BODY;
        res.valid        = 1'b1;
        res.kind         = KIND_TYPE;
        res.data         = byte_in;
      end
      ST_BODY: begin
        running_sum_next = sum_inc;
        byte_count_next  = count_inc;
        res.valid        = 1'b1;
        if (count_inc >= declared_length) begin
          // checksum position: compare against the sum before this byte
          phase_next = ST_HUNT;
          res.kind   = KIND_END;
          res.good   = (byte_in == running_sum) && (count_inc == declared_length);
          res.last   = 1'b1;
        end else begin
          res.kind = KIND_DATA;
          res.data = byte_in;
        end
      end
      default: begin
        phase_next = ST_HUNT;
      end
    endcase
  end

  // State registers advance once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ST_HUNT;
      running_sum     <= 8'd0;
      declared_length <= 8'd0;
      byte_count      <= 8'd0;
    end else if (step) begin
      phase           <= phase_next;
      running_sum     <= running_sum_next;
      declared_length <= declared_length_next;
      byte_count      <= byte_count_next;
    end
  end

  // Checks
  `CPD_ASSERT_NOW(a_hunt_silent, phase == ST_HUNT || phase == ST_LEN || phase == ST_ADDR, !res.valid)
  `CPD_ASSERT_NOW(a_last_is_end, res.valid && res.last, res.kind == KIND_END && res.data == 8'd0)
  `CPD_ASSERT_NEXT(a_type_to_body, step && phase == ST_TYPE, phase == ST_BODY)
  `CPD_ASSERT_NEXT(a_addr_miss, step && phase == ST_ADDR && byte_in != own_address, phase == ST_HUNT)

endmodule

// ----- rtl/cpd_out_reg.sv -----
// ----------------------------------------------------------------------------
// cpd_out_reg
// Result register between the parser and the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cpd_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data,
  output logic             packet_good,
  output logic             last
);
  import cpd_pkg::*;

  // Control: a load replaces the held request, a take empties the register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      kind        <= res.kind;
      data        <= res.data;
      packet_good <= res.good;
      last        <= res.last;
    end
  end

endmodule

// ----- rtl/checksum_packet_deframer_top.sv -----
// Path: input register, parser logic, result register; a stalled result holds the byte in
// the input register.
// Throughput: one byte per cycle while the result register is not stalled.
// in_stall rises only while a held input byte waits on a stalled result.
// Reset (rst, synchronous, active high): control registers 0, parser hunting, no requests.
// ----------------------------------------------------------------------------
// checksum_packet_deframer_top
// Additive checksum packet deframer with a byte-wide input channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module checksum_packet_deframer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] data,
  output logic       packet_good,
  output logic       last
);
  import cpd_pkg::*;

  logic       header_byte_q;
  logic [7:0] header_byte;
  logic [7:0] own_address;
  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  result_t    res;

  assign header_byte_q = (cfg_index == CFG_HEADER);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= 8'd0;
      own_address <= 8'd0;
    end else if (cfg_write) begin
      if (header_byte_q) begin
        header_byte <= cfg_data;
      end else if (cfg_index == CFG_ADDRESS) begin
        own_address <= cfg_data;
      end
    end
  end

  // Held byte moves on whenever the result register can take a result
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  cpd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (in_full && advance),
    .byte_in     (in_byte),
    .header_byte (header_byte),
    .own_address (own_address),
    .res         (res)
  );

  cpd_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (in_full && advance),
    .res         (res),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .data        (data),
    .packet_good (packet_good),
    .last        (last)
  );

endmodule

// ----- dv/checksum_packet_deframer_top_tb.sv -----
// ----------------------------------------------------------------------------
// checksum_packet_deframer_top_tb
// Self-checking bench for the packet deframer. A directed table covers the
// extremes and special framing cases, then random packets run under several
// header and address settings. A behavioral deframer predicts results not fixed in the table.
// Random gaps are applied on the input channel and random stalls on the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module checksum_packet_deframer_top_tb;
  import cpd_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_WAIT  = 8;
  localparam int PHASE_BYTES  = 350;

  // One deframer result as seen on the output port
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       good;
    logic       last;
  } deframe_rec_t;

  // One row of the directed table
  typedef struct packed {
    logic [7:0]   rx;
    logic         known;
    logic         has;
    deframe_rec_t rec;
  } plan_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] data;
  logic       packet_good;
  logic       last;

  // Predictor state and its copy of the registers
  phase_t       parse_ph;
  logic [7:0]   sum_acc;
  logic [7:0]   len_decl;
  logic [7:0]   body_cnt;
  logic [7:0]   hdr_cfg;
  logic [7:0]   addr_cfg;

  deframe_rec_t pending_recs[$];
  int           fail_count;
  int           bytes_sent;
  int           cycle_count;
  bit           tx_burst;
  int           rx_span;
  bit           rx_hold;
  plan_row_t    dir_plan [26];

  checksum_packet_deframer_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .data        (data),
    .packet_good (packet_good),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("checksum_packet_deframer_top_tb: FAIL");
      $finish;
    end
  end

  function automatic void flag_error(input string msg);
    fail_count = fail_count + 1;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Behavioral deframer: advances the state by one byte, returns any result
  function automatic void deframe_byte(input logic [7:0] b, output bit has,
                                       output deframe_rec_t rec);
    logic [7:0] sum_before;
    has = 1'b0;
    rec = '0;
    case (parse_ph)
      ST_LEN: begin
        sum_acc  = sum_acc + b;
        len_decl = b;
        body_cnt = 8'd0;
        parse_ph = ST_ADDR;
      end
      ST_ADDR: begin
        sum_acc  = sum_acc + b;
        body_cnt = body_cnt + 8'd1;
        parse_ph = (b == addr_cfg) ? ST_TYPE : ST_HUNT;
      end
      ST_TYPE: begin
        sum_acc  = sum_acc + b;
        body_cnt = body_cnt + 8'd1;
        parse_ph = ST_BODY;
        has = 1'b1;
        rec = '{kind: KIND_TYPE, data: b, good: 1'b0, last: 1'b0};
      end
      ST_BODY: begin
        sum_before = sum_acc;
        sum_acc    = sum_acc + b;
        body_cnt   = body_cnt + 8'd1;
        has = 1'b1;
        // checksum byte once the count reaches or passes the length
        if (body_cnt >= len_decl) begin
          rec = '{kind: KIND_END, data: 8'h00,
                  good: (b == sum_before) && (body_cnt == len_decl), last: 1'b1};
          parse_ph = ST_HUNT;
        end else begin
          rec = '{kind: KIND_DATA, data: b, good: 1'b0, last: 1'b0};
        end
      end
      default: begin
        sum_acc  = b;
        parse_ph = (b == hdr_cfg) ? ST_LEN : ST_HUNT;
      end
    endcase
  endfunction

  // Table row builders
  function automatic plan_row_t row_pred(input logic [7:0] b);
    return '{rx: b, known: 1'b0, has: 1'b0, rec: '0};
  endfunction

  function automatic plan_row_t row_quiet(input logic [7:0] b);
    return '{rx: b, known: 1'b1, has: 1'b0, rec: '0};
  endfunction

  function automatic plan_row_t row_known(input logic [7:0] b, input logic [1:0] k,
                                          input logic [7:0] d, input logic g);
    return '{rx: b, known: 1'b1, has: 1'b1,
             rec: '{kind: k, data: d, good: g, last: (k == KIND_END)}};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Send one request; on acceptance record the expected result
  task automatic send_byte(input logic [7:0] b, input logic known, input logic has_known,
                           input deframe_rec_t rec_known);
    int           gap;
    bit           has;
    deframe_rec_t rec;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    deframe_byte(b, has, rec);
    if (known) begin
      has = has_known;
      rec = rec_known;
    end
    if (has) pending_recs.push_back(rec);
    bytes_sent = bytes_sent + 1;
  endtask

  // Hold requests off until every result is in and the pipeline is empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] hdr, input logic [7:0] addr);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_HEADER;
    cfg_data  <= hdr;
    @(posedge clk);
    hdr_cfg = hdr;
    @(negedge clk);
    cfg_index <= CFG_ADDRESS;
    cfg_data  <= addr;
    @(posedge clk);
    addr_cfg = addr;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // One random packet, a burst of noise, or a packet cut short
  task automatic send_packet(input int force_len);
    int         r;
    int         len;
    int         total;
    int         cut;
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] addr;
    tx_burst = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
      return;
    end
    if (force_len >= 0) begin
      len = force_len;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 82) len = $urandom_range(3, 12);
      else if (r < 94) len = $urandom_range(0, 2);
      else len = $urandom_range(13, 255);
    end
    addr  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : addr_cfg;
    total = 4 + ((len >= 3) ? len - 2 : 1);
    cut   = ($urandom_range(0, 19) == 0) ? $urandom_range(1, total - 1) : total;
    sum   = 8'h00;
    for (int k = 0; k < cut; k++) begin
      if (k == 0) b = hdr_cfg;
      else if (k == 1) b = 8'(len);
      else if (k == 2) b = addr;
      else if (k < total - 1) b = 8'($urandom);
      else b = ($urandom_range(0, 3) != 0) ? sum : 8'($urandom);
      sum = sum + b;
      send_byte(b, 1'b0, 1'b0, '0);
    end
  endtask

  // Receiver stall pattern: short and long stalls, with clear stretches
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_span = 0;
      rx_hold = 1'b0;
    end else if (rx_span > 0) begin
      rx_span = rx_span - 1;
    end else begin
      rx_hold = !rx_hold;
      if (rx_hold)
        rx_span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 2);
      else
        rx_span = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 5);
      out_stall <= rx_hold;
    end
  end

  // Result checker
  always @(posedge clk) begin
    deframe_rec_t got;
    deframe_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{kind: kind, data: data, good: packet_good, last: last};
      if (pending_recs.size() == 0) begin
        flag_error($sformatf("unexpected result: kind=%0d data=%02h good=%0b last=%0b",
                             got.kind, got.data, got.good, got.last));
      end else begin
        want = pending_recs.pop_front();
        if (got.kind !== want.kind || got.data !== want.data ||
            got.good !== want.good || got.last !== want.last)
          flag_error($sformatf(
            "mismatch: exp kind/data/good/last=%0d/%02h/%0b/%0b, got %0d/%02h/%0b/%0b",
            want.kind, want.data, want.good, want.last,
            got.kind, got.data, got.good, got.last));
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0] hdr_set  [5];
    logic [7:0] addr_set [5];
    int         target;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = CFG_HEADER;
    cfg_data    = 8'h00;
    in_valid    = 1'b0;
    rx_byte     = 8'h00;
    fail_count  = 0;
    bytes_sent  = 0;
    cycle_count = 0;
    tx_burst    = 1'b0;
    parse_ph    = ST_HUNT;
    sum_acc     = 8'h00;
    len_decl    = 8'h00;
    body_cnt    = 8'h00;
    hdr_cfg     = 8'h00;
    addr_cfg    = 8'h00;
    hdr_set     = '{8'hFF, 8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    addr_set    = '{8'hFF, 8'hFF, 8'h00, 8'($urandom), 8'($urandom)};

    // Directed table, header 00 and address 00
    dir_plan = '{
      row_quiet(8'h33),                          // not a header: dropped
      row_quiet(8'h00), row_quiet(8'h03), row_quiet(8'h00),
      row_known(8'h5A, KIND_TYPE, 8'h5A, 1'b0),
      row_known(8'h5D, KIND_END,  8'h00, 1'b1),  // minimal good packet
      row_quiet(8'h00), row_quiet(8'h03),
      row_quiet(8'h7E),                          // wrong address: back to hunting
      row_quiet(8'h00),                          // fresh header right after
      row_quiet(8'h01), row_quiet(8'h00),        // length below 3
      row_known(8'h11, KIND_TYPE, 8'h11, 1'b0),
      row_known(8'h22, KIND_END,  8'h00, 1'b0),
      row_quiet(8'h00), row_quiet(8'h05), row_quiet(8'h00),
      row_known(8'hFF, KIND_TYPE, 8'hFF, 1'b0),
      row_known(8'hFF, KIND_DATA, 8'hFF, 1'b0),
      row_known(8'h00, KIND_DATA, 8'h00, 1'b0),
      row_pred(8'h04),                           // bad checksum
      row_quiet(8'h00), row_quiet(8'h00), row_quiet(8'h00),  // length zero
      row_known(8'h80, KIND_TYPE, 8'h80, 1'b0),
      row_known(8'h55, KIND_END,  8'h00, 1'b0)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_config(8'h00, 8'h00);
    foreach (dir_plan[i])
      send_byte(dir_plan[i].rx, dir_plan[i].known, dir_plan[i].has, dir_plan[i].rec);

    // Random phases, each under its own header and address
    for (int p = 0; p < 5; p++) begin
      drain();
      load_config(hdr_set[p], addr_set[p]);
      target = bytes_sent + PHASE_BYTES;
      if (p == 3) send_packet(255);
      while (bytes_sent < target) begin
        send_packet(-1);
        if ($urandom_range(0, 99) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_recs.size() == 0) begin
      $display("checksum_packet_deframer_top_tb: PASS");
    end else begin
      $display("checksum_packet_deframer_top_tb: FAIL");
    end
    $finish;
  end

endmodule
